[hdl/stom_pkg.sv]
// shared types and constants for the sensor time offset median block
// no dependencies; imported by every module of the block

package stom_pkg;

  // field widths
  localparam int STAMP_W  = 48;
  localparam int OFFSET_W = 49;
  localparam int LIMIT_W  = 20;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd10000;

  // inertial stamp ring
  localparam int INERTIAL_DEPTH = 1024;
  localparam int INERTIAL_AW    = (INERTIAL_DEPTH > 1) ? $clog2(INERTIAL_DEPTH) : 1;
  localparam int INERTIAL_FW    = $clog2(INERTIAL_DEPTH + 1);
  localparam int SCAN_CW        = $clog2(INERTIAL_DEPTH + 2);

  // offset window
  localparam int WINDOW_DEPTH = 10;
  localparam int WINDOW_AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WINDOW_CW    = $clog2(WINDOW_DEPTH + 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] stamp_us;
  } stom_in_t;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] median_offset_us;
    logic                       offset_large;
    logic [STAMP_W-1:0]         nearest_stamp_us;
  } stom_out_t;

  // classified operation
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_MATCH = 1'b1
  } stom_op_t;

  typedef struct packed {
    stom_op_t           op;
    logic [STAMP_W-1:0] stamp;
  } stom_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stom_q_status_t;

endpackage

[hdl/stom_front.sv]
// front stage: takes input requests, classifies them and pushes them into the queue
// depends on stom_pkg

module stom_front import stom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  stom_in_t    in_data,
  input  logic        q_full,
  output logic        push,
  output stom_entry_t push_entry
);

  logic        slot_vld;
  stom_entry_t slot;
  logic        accept;

  // slot drains into the queue whenever there is room
  assign in_stall   = slot_vld & q_full;
  assign push       = slot_vld & ~q_full;
  assign push_entry = slot;
  assign accept     = in_valid & ~in_stall;

  // slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= 1'b0;
    end else if (accept) begin
      slot_vld <= 1'b1;
    end else if (push) begin
      slot_vld <= 1'b0;
    end
  end

  // classify the request
  always_ff @(posedge clk) begin
    if (accept) begin
      slot.op    <= in_data.kind ? OP_MATCH : OP_STORE;
      slot.stamp <= in_data.stamp_us;
    end
  end

endmodule

[hdl/stom_queue.sv]
// short request queue between the front and back parts
// depends on stom_pkg

module stom_queue import stom_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stom_entry_t    push_entry,
  input  logic           pop,
  output stom_q_status_t status,
  output stom_entry_t    head_entry
);

  stom_entry_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_entry   = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[hdl/stom_back.sv]
// back part: stamp ring memory, nearest-stamp scan, offset window and median select
// depends on stom_pkg

module stom_back import stom_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  stom_q_status_t     q_status,
  input  stom_entry_t        head_entry,
  output logic               pop,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output stom_out_t          out_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_PUSH = 8'b0000_0100,
    S_SEL  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_CNT  = 8'b0010_0000,
    S_MAG  = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // ring state
  logic [STAMP_W-1:0]     ring [INERTIAL_DEPTH];
  logic [INERTIAL_AW-1:0] ring_head;
  logic [INERTIAL_FW-1:0] ring_fill;
  logic                   ring_we;
  logic [INERTIAL_AW-1:0] newest;
  logic [INERTIAL_AW-1:0] oldest;
  logic [INERTIAL_FW:0]   head_x;
  logic [INERTIAL_FW:0]   fill_x;
  logic [INERTIAL_FW:0]   old_sum;

  // scan state
  logic [STAMP_W-1:0]     lidar;
  logic [SCAN_CW-1:0]     scan_len;
  logic [SCAN_CW-1:0]     iss_cnt;
  logic [INERTIAL_AW-1:0] walk;
  logic                   rd_en;
  logic [INERTIAL_AW-1:0] rd_addr;
  logic [STAMP_W-1:0]     rd_data;
  logic                   rd_vld;
  logic                   rd_first;
  logic [STAMP_W-1:0]     d_diff;
  logic [STAMP_W-1:0]     d_cand;
  logic                   d_vld;
  logic                   d_first;
  logic [STAMP_W-1:0]     best;
  logic [STAMP_W-1:0]     best_diff;
  logic [STAMP_W-1:0]     abs_diff;
  logic                   scan_done;

  // window state
  logic signed [OFFSET_W-1:0] win [WINDOW_DEPTH];
  logic [WINDOW_AW-1:0]       win_head;
  logic [WINDOW_CW-1:0]       win_fill;
  logic [WINDOW_AW-1:0]       ci;
  logic signed [OFFSET_W-1:0] cand;
  logic [WINDOW_DEPTH-1:0]    ltv;
  logic [WINDOW_DEPTH-1:0]    lev;
  logic [WINDOW_CW-1:0]       lt_cnt;
  logic [WINDOW_CW-1:0]       le_cnt;
  logic [WINDOW_CW-1:0]       mid;
  logic                       hit;
  logic signed [OFFSET_W-1:0] offset;
  logic signed [OFFSET_W-1:0] median;
  logic [OFFSET_W-1:0]        neg_median;
  logic [STAMP_W-1:0]         mag;

  logic [LIMIT_W-1:0] limit;
  logic               out_free;

  function automatic logic [WINDOW_CW-1:0] count_ones(input logic [WINDOW_DEPTH-1:0] v);
    logic [WINDOW_CW-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      n = n + WINDOW_CW'(v[i]);
    end
    return n;
  endfunction

  // ring pointers: newest entry and oldest entry
  assign newest  = (ring_head == '0) ? INERTIAL_AW'(INERTIAL_DEPTH - 1) : ring_head - 1'b1;
  assign head_x  = (INERTIAL_FW + 1)'(ring_head);
  assign fill_x  = (INERTIAL_FW + 1)'(ring_fill);
  assign old_sum = (head_x >= fill_x) ? head_x - fill_x
                                      : head_x + (INERTIAL_FW + 1)'(INERTIAL_DEPTH) - fill_x;
  assign oldest  = old_sum[INERTIAL_AW-1:0];

  assign pop     = (state == S_IDLE) && !q_status.empty;
  assign ring_we = pop && (head_entry.op == OP_STORE);

  // scan read issue: newest first, then oldest through newest
  assign rd_en     = (state == S_SCAN) && (iss_cnt != scan_len);
  assign rd_addr   = (iss_cnt == '0) ? newest : walk;
  assign abs_diff  = (lidar >= rd_data) ? lidar - rd_data : rd_data - lidar;
  assign scan_done = (state == S_SCAN) && (iss_cnt == scan_len) && !rd_vld && !d_vld;

  // median select
  assign offset     = {1'b0, lidar} - {1'b0, best};
  assign lt_cnt     = count_ones(ltv);
  assign le_cnt     = count_ones(lev);
  assign mid        = win_fill >> 1;
  assign hit        = (lt_cnt <= mid) && (mid < le_cnt);
  assign neg_median = -median;
  assign out_free   = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop && head_entry.op == OP_MATCH && ring_fill != '0) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH:  state_next = S_SEL;
      S_SEL:   state_next = S_CMP;
      S_CMP:   state_next = S_CNT;
      S_CNT:   state_next = hit ? S_MAG : S_SEL;
      S_MAG:   state_next = S_RES;
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ring_head <= '0;
      ring_fill <= '0;
      win_head  <= '0;
      win_fill  <= '0;
      rd_vld    <= 1'b0;
      d_vld     <= 1'b0;
      out_valid <= 1'b0;
      limit     <= LIMIT_RESET;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      d_vld  <= rd_vld;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      // store request advances the ring
      if (ring_we) begin
        ring_head <= (ring_head == INERTIAL_AW'(INERTIAL_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        if (ring_fill != INERTIAL_FW'(INERTIAL_DEPTH)) begin
          ring_fill <= ring_fill + 1'b1;
        end
      end
      // new offset enters the window
      if (state == S_PUSH) begin
        win_head <= (win_head == WINDOW_AW'(WINDOW_DEPTH - 1)) ? '0 : win_head + 1'b1;
        if (win_fill != WINDOW_CW'(WINDOW_DEPTH)) begin
          win_fill <= win_fill + 1'b1;
        end
      end
      // result register
      if (state == S_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_head] <= head_entry.stamp;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (pop && head_entry.op == OP_MATCH) begin
      lidar    <= head_entry.stamp;
      scan_len <= SCAN_CW'(ring_fill) + 1'b1;
      iss_cnt  <= '0;
      walk     <= oldest;
    end
    if (rd_en) begin
      iss_cnt <= iss_cnt + 1'b1;
      if (iss_cnt != '0) begin
        walk <= (walk == INERTIAL_AW'(INERTIAL_DEPTH - 1)) ? '0 : walk + 1'b1;
      end
    end
    rd_first <= (iss_cnt == '0);
    // distance stage
    d_diff  <= abs_diff;
    d_cand  <= rd_data;
    d_first <= rd_first;
    // keep the closest; later ties do not replace
    if (d_vld && (d_first || d_diff < best_diff)) begin
      best      <= d_cand;
      best_diff <= d_diff;
    end
  end

  // window and rank-based median select
  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      win[win_head] <= offset;
      ci            <= '0;
    end
    if (state == S_SEL) begin
      cand <= win[ci];
    end
    if (state == S_CMP) begin
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        ltv[j] <= (WINDOW_CW'(j) < win_fill) && (win[j] < cand);
        lev[j] <= (WINDOW_CW'(j) < win_fill) && (win[j] <= cand);
      end
    end
    if (state == S_CNT) begin
      if (hit) begin
        median <= cand;
      end else begin
        ci <= ci + 1'b1;
      end
    end
    if (state == S_MAG) begin
      mag <= median[OFFSET_W-1] ? neg_median[STAMP_W-1:0] : median[STAMP_W-1:0];
    end
    if (state == S_RES && out_free) begin
      out_data.median_offset_us <= median;
      out_data.offset_large     <= (mag > STAMP_W'(limit));
      out_data.nearest_stamp_us <= best;
    end
  end

endmodule

[hdl/sensor_time_offset_median.sv]
// sensor time offset median, top level: front classifier, request queue, back engine
// an inertial store request is written to the ring as it leaves the queue; a lidar request
// runs the ring scan (one memory read per stored stamp, plus a first read of the newest)
// and then the median select
// input side takes one request per cycle until the four-entry queue fills
// synchronous active-high reset empties the ring, the window and the queue, limit to 10000

module sensor_time_offset_median import stom_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  stom_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stom_out_t          out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  logic           push;
  stom_entry_t    push_entry;
  logic           pop;
  stom_q_status_t q_status;
  stom_entry_t    head_entry;

  // accept and classify
  stom_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_status.full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  stom_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .status     (q_status),
    .head_entry (head_entry)
  );

  // execution
  stom_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_entry (head_entry),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[hdl/stom_checker.sv]
// port-level checks for sensor_time_offset_median, attached with a bind
// depends on stom_pkg

module stom_checker import stom_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input stom_out_t          out_data,
  input logic               cfg_we,
  input logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0]  limit_seen;
  logic [OFFSET_W-1:0] mag_seen;
  logic                large_seen;

  // shadow of the alarm limit as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_seen <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_seen <= cfg_wdata;
    end
  end

  assign mag_seen   = out_data.median_offset_us[OFFSET_W-1] ?
                      OFFSET_W'(0) - out_data.median_offset_us : out_data.median_offset_us;
  assign large_seen = (mag_seen > OFFSET_W'(limit_seen));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // alarm flag agrees with the median and the limit in force
  a_flag: assert property (@(posedge clk) disable iff (rst || cfg_we)
    out_valid |-> out_data.offset_large == large_seen)
    else $error("offset_large does not match median magnitude");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // offsets of two 48-bit stamps never reach the most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.median_offset_us != {1'b1, {(OFFSET_W - 1){1'b0}}})
    else $error("median offset out of range");

endmodule

bind sensor_time_offset_median stom_checker u_stom_checker (.*);

[dv/sensor_time_offset_median_test.sv]
// self-checking testbench for sensor_time_offset_median: stamp stores, lidar matches,
// nearest-stamp search, sliding upper median and alarm flag against an in-bench model
// depends on stom_pkg and the sensor_time_offset_median rtl only
`timescale 1ns / 1ps

module sensor_time_offset_median_test;
  import stom_pkg::*;

  localparam int SETTLE_CYCLES = 1100;
  localparam int DIR_ROWS      = 22;
  localparam int HOLD_CYCLES   = 2000;

  localparam logic [STAMP_W-1:0]         STAMP_MAX  = '1;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, STAMP_MAX};

  typedef struct packed {
    stom_op_t  op;
    logic [STAMP_W-1:0] stamp;
    logic      typed;
    stom_out_t result;
  } stamp_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  stom_in_t in_data;
  logic out_valid;
  logic out_stall;
  stom_out_t out_data;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  // model of the block
  logic [STAMP_W-1:0] imu_ring [INERTIAL_DEPTH];
  int imu_head;
  int imu_fill;
  logic signed [OFFSET_W-1:0] offset_hist [WINDOW_DEPTH];
  int hist_head;
  int hist_fill;
  logic [LIMIT_W-1:0] alarm_limit;
  stom_out_t pending_medians [$];

  // bookkeeping
  int mismatch_count = 0;
  int results_seen = 0;
  int stores_sent = 0;
  int matches_sent = 0;
  int empty_matches = 0;
  int limit_writes = 0;
  int burst_left = 0;
  int pressure_left = 0;
  int hold_request = 0;

  // directed requests; expected values typed in only where obvious
  stamp_row_t dir_table [DIR_ROWS] = '{
    '{OP_MATCH, 48'd5, 1'b0, '0},                              // empty ring
    '{OP_STORE, 48'd0, 1'b0, '0},
    '{OP_MATCH, STAMP_MAX, 1'b1, '{OFFSET_MAX, 1'b1, 48'd0}},
    '{OP_STORE, STAMP_MAX, 1'b0, '0},
    '{OP_MATCH, 48'd0, 1'b1, '{OFFSET_MAX, 1'b1, 48'd0}},      // older exact hit
    '{OP_MATCH, 48'd0, 1'b1, '{49'sd0, 1'b0, 48'd0}},
    '{OP_STORE, 48'd100, 1'b0, '0},
    '{OP_STORE, 48'd200, 1'b0, '0},
    '{OP_MATCH, 48'd150, 1'b0, '0},                            // tie keeps newest
    '{OP_STORE, 48'd140, 1'b0, '0},
    '{OP_STORE, 48'd160, 1'b0, '0},
    '{OP_STORE, 48'd1000, 1'b0, '0},
    '{OP_MATCH, 48'd150, 1'b0, '0},                            // oldest of equal older
    '{OP_MATCH, 48'd10150, 1'b0, '0},
    '{OP_MATCH, 48'd11001, 1'b0, '0},
    '{OP_STORE, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
    '{OP_MATCH, 48'h5555_5555_5555, 1'b0, '0},
    '{OP_STORE, 48'h5555_5555_5555, 1'b0, '0},
    '{OP_MATCH, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
    '{OP_MATCH, 48'd15000, 1'b0, '0},                          // tenth offset fills the window
    '{OP_MATCH, 48'd1, 1'b0, '0},
    '{OP_MATCH, STAMP_MAX, 1'b0, '0}
  };

  sensor_time_offset_median dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [STAMP_W-1:0] stamp_gap(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {16'($urandom), $urandom};
  endfunction

  function automatic void store_imu(input logic [STAMP_W-1:0] stamp);
    imu_ring[imu_head] = stamp;
    imu_head = (imu_head + 1 >= INERTIAL_DEPTH) ? 0 : imu_head + 1;
    if (imu_fill < INERTIAL_DEPTH) imu_fill++;
  endfunction

  // nearest stored stamp, offset into the window, upper median and alarm flag
  function automatic bit match_lidar(input logic [STAMP_W-1:0] lidar, output stom_out_t res);
    int newest;
    int idx;
    int i;
    int j;
    logic [STAMP_W-1:0] best;
    logic [STAMP_W-1:0] best_gap;
    logic [STAMP_W-1:0] gap;
    logic signed [OFFSET_W-1:0] sorted_offs [WINDOW_DEPTH];
    logic signed [OFFSET_W-1:0] v;
    logic signed [OFFSET_W-1:0] med;
    logic [OFFSET_W-1:0] mag;
    res = '0;
    if (imu_fill == 0) return 1'b0;
    newest = (imu_head == 0) ? INERTIAL_DEPTH - 1 : imu_head - 1;
    best = imu_ring[newest];
    best_gap = stamp_gap(lidar, best);
    idx = (imu_head >= imu_fill) ? imu_head - imu_fill : imu_head + INERTIAL_DEPTH - imu_fill;
    // scan oldest to newest, only a strictly smaller gap replaces
    for (i = 0; i < imu_fill; i++) begin
      gap = stamp_gap(lidar, imu_ring[idx]);
      if (gap < best_gap) begin
        best_gap = gap;
        best = imu_ring[idx];
      end
      idx = (idx + 1 >= INERTIAL_DEPTH) ? 0 : idx + 1;
    end
    offset_hist[hist_head] = {1'b0, lidar} - {1'b0, best};
    hist_head = (hist_head + 1 >= WINDOW_DEPTH) ? 0 : hist_head + 1;
    if (hist_fill < WINDOW_DEPTH) hist_fill++;
    // insertion sort of the window, pick element fill/2
    for (i = 0; i < hist_fill; i++) sorted_offs[i] = offset_hist[i];
    for (i = 1; i < hist_fill; i++) begin
      v = sorted_offs[i];
      j = i;
      while (j > 0 && sorted_offs[j-1] > v) begin
        sorted_offs[j] = sorted_offs[j-1];
        j--;
      end
      sorted_offs[j] = v;
    end
    med = sorted_offs[hist_fill / 2];
    mag = med[OFFSET_W-1] ? -med : med;
    res.median_offset_us = med;
    res.offset_large = (mag > alarm_limit);
    res.nearest_stamp_us = best;
    return 1'b1;
  endfunction

  function automatic void predict_request(input stom_in_t req, input bit use_typed,
                                          input stom_out_t typed_res);
    stom_out_t res;
    if (req.kind == OP_STORE) begin
      store_imu(req.stamp_us);
      stores_sent++;
    end else begin
      matches_sent++;
      if (match_lidar(req.stamp_us, res))
        pending_medians.insert(pending_medians.size(), use_typed ? typed_res : res);
      else
        empty_matches++;
    end
  endfunction

  // drive one request from a falling edge, return at the falling edge after acceptance
  task automatic send_request(input stom_in_t req, input bit use_typed,
                              input stom_out_t typed_res);
    in_valid = 1'b1;
    in_data = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req, use_typed, typed_res);
    @(negedge clk);
  endtask

  // bursts of requests with random gaps between them
  task automatic offer(input stom_in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (pressure_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    send_request(req, 1'b0, '0);
    burst_left--;
    if (pressure_left > 0) pressure_left--;
  endtask

  // sender pauses until every result is back, then lets the block go quiet
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_alarm_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    alarm_limit = value;
    limit_writes++;
  endtask

  // mostly imu runs followed by a lidar stamp near them, some noise
  task automatic random_chunk(input int n_items);
    int sent;
    int k;
    int step;
    stom_in_t req;
    logic [STAMP_W-1:0] prev_stamp;
    logic [STAMP_W-1:0] last_stamp;
    logic [STAMP_W-1:0] lidar;
    sent = 0;
    last_stamp = rand_stamp();
    prev_stamp = last_stamp;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        step = $urandom_range(1, 3 * int'(alarm_limit) + 3);
        k = $urandom_range(1, 6);
        repeat (k) begin
          prev_stamp = last_stamp;
          // occasionally repeat the same stamp
          if ($urandom_range(0, 7) != 0)
            last_stamp = last_stamp + STAMP_W'(step) + STAMP_W'($urandom_range(0, step / 8));
          req.kind = OP_STORE;
          req.stamp_us = last_stamp;
          offer(req);
          sent++;
        end
        case ($urandom_range(0, 3))
          0: lidar = STAMP_W'(({1'b0, prev_stamp} + {1'b0, last_stamp}) >> 1);
          1: lidar = last_stamp;
          default: lidar = last_stamp + STAMP_W'($urandom_range(0, 2 * step)) - STAMP_W'(step);
        endcase
        req.kind = OP_MATCH;
        req.stamp_us = lidar;
        offer(req);
        sent++;
      end else begin
        req.kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: req.stamp_us = '0;
          1: req.stamp_us = STAMP_MAX;
          2: req.stamp_us = last_stamp ^ (48'd1 << $urandom_range(0, STAMP_W - 1));
          default: req.stamp_us = rand_stamp();
        endcase
        offer(req);
        sent++;
      end
    end
  endtask

  // stamps at both ends of the range, then lidar stamps at the extremes
  task automatic extremes_phase();
    stom_in_t req;
    int i;
    req.kind = OP_STORE;
    for (i = 1; i <= 10; i++) begin
      req.stamp_us = STAMP_W'(i);
      offer(req);
    end
    for (i = 0; i < 12; i++) begin
      req.stamp_us = STAMP_MAX - STAMP_W'($urandom_range(0, 100000));
      offer(req);
    end
    req.kind = OP_MATCH;
    req.stamp_us = '0;
    repeat (2) offer(req);
    req.stamp_us = STAMP_MAX;
    offer(req);
    repeat (6) begin
      req.stamp_us = STAMP_MAX - STAMP_W'($urandom_range(0, 200000));
      offer(req);
    end
    req.kind = OP_STORE;
    req.stamp_us = STAMP_MAX;
    repeat (4) offer(req);
    req.kind = OP_MATCH;
    req.stamp_us = '0;
    repeat (6) offer(req);
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  // check each returned result against the oldest pending one
  always @(posedge clk) begin : check_results
    stom_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_medians.size() == 0) begin
        note_mismatch("unexpected result median", '0, 64'(out_data.median_offset_us));
      end else begin
        want = pending_medians[0];
        pending_medians.delete(0);
        if (out_data.median_offset_us !== want.median_offset_us)
          note_mismatch("median_offset_us", 64'(want.median_offset_us),
                        64'(out_data.median_offset_us));
        if (out_data.offset_large !== want.offset_large)
          note_mismatch("offset_large", 64'(want.offset_large), 64'(out_data.offset_large));
        if (out_data.nearest_stamp_us !== want.nearest_stamp_us)
          note_mismatch("nearest_stamp_us", 64'(want.nearest_stamp_us),
                        64'(out_data.nearest_stamp_us));
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall = 1'b1;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = 1'($urandom_range(0, 1));
          2: out_stall = ($urandom_range(0, 9) != 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("[sensor_time_offset_median] ERROR");
    $finish;
  end

  // main sequence
  initial begin
    int i;
    stom_in_t req;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst = 1'b1;
    imu_head = 0;
    imu_fill = 0;
    hist_head = 0;
    hist_fill = 0;
    alarm_limit = LIMIT_RESET;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed requests at the reset limit
    for (i = 0; i < DIR_ROWS; i++) begin
      req.kind = dir_table[i].op;
      req.stamp_us = dir_table[i].stamp;
      send_request(req, dir_table[i].typed, dir_table[i].result);
    end

    write_alarm_limit('0);
    random_chunk(100);
    write_alarm_limit(20'd1000000);
    random_chunk(100);

    // long receiver hold-off while the sender keeps offering
    write_alarm_limit(LIMIT_W'($urandom_range(0, 1000000)));
    hold_request = HOLD_CYCLES;
    pressure_left = 60;
    random_chunk(110);

    write_alarm_limit(20'd1);
    random_chunk(100);
    write_alarm_limit(LIMIT_W'($urandom_range(0, 1000000)));
    random_chunk(100);

    write_alarm_limit(LIMIT_W'($urandom_range(0, 1000000)));
    extremes_phase();
    drain_results();

    if (pending_medians.size() != 0) begin
      $display("%0d expected results never came out", pending_medians.size());
      mismatch_count += pending_medians.size();
    end
    $display("sent %0d stamp stores and %0d lidar stamps (%0d on an empty ring), %0d results",
             stores_sent, matches_sent, empty_matches, results_seen);
    $display("alarm limit written %0d times incl. 0 and 1000000, stamps at both range ends",
             limit_writes);
    if (mismatch_count == 0)
      $display("[sensor_time_offset_median] OK");
    else
      $display("[sensor_time_offset_median] ERROR");
    $finish;
  end

endmodule

[sim.f]
hdl/stom_pkg.sv
hdl/stom_front.sv
hdl/stom_queue.sv
hdl/stom_back.sv
hdl/sensor_time_offset_median.sv
hdl/stom_checker.sv
dv/sensor_time_offset_median_test.sv
